// ===== src/dslp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslp_pkg
// Shared types and constants for the depth snapshot line parser.
// ----------------------------------------------------------------------------
package dslp_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic        line_handled;
        logic [2:0]  status_code;
        logic [63:0] session_number;
        logic [63:0] depth_seq;
        logic [2:0]  level_slot;
        logic [63:0] price_ticks;
        logic [63:0] quantity_lots;
        logic [31:0] order_total;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [63:0] price;
        logic [63:0] qty;
        logic [31:0] orders;
    } level_t;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_BID    = 2'd1;
    localparam logic [1:0] KIND_ASK    = 2'd2;

    localparam logic [2:0] ST_WAIT_DATA  = 3'd0;
    localparam logic [2:0] ST_WAIT_DEPTH = 3'd1;
    localparam logic [2:0] ST_LIVE       = 3'd2;
    localparam logic [2:0] ST_BAD_SESS   = 3'd3;
    localparam logic [2:0] ST_BAD_BID    = 3'd4;
    localparam logic [2:0] ST_BAD_ASK    = 3'd5;
    localparam logic [2:0] ST_BAD_DEPTH  = 3'd6;
    localparam logic [2:0] ST_INCOMPLETE = 3'd7;

    typedef enum logic [2:0] {
        PH_PREFIX, PH_IGNORE, PH_SESSION, PH_DEPTH, PH_FAILED
    } phase_t;

    typedef enum logic [2:0] {
        TK_EMPTY, TK_KEY_SEQ, TK_KEY_BID, TK_KEY_ASK, TK_VAL_SEQ, TK_VAL_BID, TK_VAL_ASK
    } tok_t;

    typedef enum logic [1:0] {
        CS_IDLE, CS_STATUS, CS_BIDS, CS_ASKS
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic parse;       // consume the accepted byte
        logic emit_load;   // load output register
        logic [1:0] kind;
        logic last;
        logic slot_clr;
        logic slot_inc;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic commit;      // byte just parsed ended a line with a commit
        logic slot_last;
    } dp_stat_t;

    localparam logic [63:0] TXT_SESSION = "SESSION ";
    localparam logic [47:0] TXT_DEPTH   = "DEPTH ";
    localparam logic [31:0] TXT_SEQ     = "seq=";

    function automatic logic [7:0] sess_char(input logic [3:0] p);
        logic [2:0] k;
        k = 3'(7 - p[2:0]);
        return TXT_SESSION[k*8 +: 8];
    endfunction

    function automatic logic [7:0] depth_char(input logic [3:0] p);
        logic [2:0] k;
        k = 3'(5 - p[2:0]);
        return TXT_DEPTH[k*8 +: 8];
    endfunction

    function automatic logic [7:0] seq_char(input logic [3:0] p);
        logic [1:0] k;
        k = 2'(3 - p[1:0]);
        return TXT_SEQ[k*8 +: 8];
    endfunction

endpackage

// ===== src/dslp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslp_datapath
// Byte parser, working and committed books, output register.
// ----------------------------------------------------------------------------
module dslp_datapath #(
    parameter int LEVELS = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dslp_pkg::in_item_t  in_item,
    input  dslp_pkg::dp_cmd_t   cmd,
    output dslp_pkg::dp_stat_t  stat,
    output dslp_pkg::out_item_t out_item
);
    import dslp_pkg::*;

    localparam int CW = $clog2(LEVELS + 1);
    localparam int SW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    phase_t       phase_reg, phase_next;
    tok_t         kind_reg, kind_next;
    logic [3:0]   pos_reg, pos_next;
    logic [1:0]   field_reg, field_next;
    logic         seen_reg, seen_next, bad_reg, bad_next, hseq_reg, hseq_next;
    logic         which_reg, which_next; // 1 = SESSION
    logic [CW-1:0] bcnt_reg, bcnt_next, acnt_reg, acnt_next;
    logic [2:0]   err_reg, err_next;
    logic [63:0]  acc_reg, acc_next;
    logic [63:0]  wseq_reg, wseq_next;

    logic [63:0]  sess_reg, sess_next, seq_reg, seq_next;
    logic [2:0]   status_reg, status_next;
    logic         handled_reg, handled_next;
    logic         commit_reg, commit_next;

    level_t       wbid [LEVELS];
    level_t       wask [LEVELS];
    level_t       bid_reg [LEVELS];
    level_t       ask_reg [LEVELS];

    // working-book write strobes
    logic         wr_price, wr_qty, wr_ord, wr_bid;
    logic [CW-1:0] wr_slot_w;
    logic [SW-1:0] wr_slot;
    logic [SW-1:0] slot_reg;
    out_item_t    out_reg;

    // number step: acc*10+d with overflow check against a limit
    logic [7:0]   c;
    logic         is_digit;
    logic [3:0]   dval;
    logic [67:0]  prod;
    logic         ovf64, ovf32;

    assign c        = in_item.char_byte;
    assign is_digit = (c >= "0") && (c <= "9");
    assign dval     = 4'(c - "0");
    assign prod     = {4'd0, acc_reg} * 68'd10 + {64'd0, dval};
    assign ovf64    = |prod[67:64];
    assign ovf32    = |prod[67:32];
    assign wr_slot  = wr_slot_w[SW-1:0];

    always_comb
    begin
        logic eol, is_bid, lvl_ovf, fin_ok;
        logic [2:0] code;
        logic [CW-1:0] cnt;
        phase_next = phase_reg; kind_next = kind_reg; pos_next = pos_reg;
        field_next = field_reg; seen_next = seen_reg; bad_next = bad_reg;
        hseq_next = hseq_reg; which_next = which_reg; bcnt_next = bcnt_reg;
        acnt_next = acnt_reg; err_next = err_reg; acc_next = acc_reg;
        wseq_next = wseq_reg; sess_next = sess_reg; seq_next = seq_reg;
        status_next = status_reg; handled_next = handled_reg;
        commit_next = 1'b0;
        wr_price = 1'b0; wr_qty = 1'b0; wr_ord = 1'b0; wr_bid = 1'b0;
        wr_slot_w = '0;
        eol = in_item.end_of_line;
        is_bid = 1'b0; lvl_ovf = 1'b0; fin_ok = 1'b0;
        code = ST_BAD_DEPTH; cnt = '0;

        if (cmd.parse)
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (pos_reg == 4'd0 && c != "S" && c != "D")
                        phase_next = PH_IGNORE;
                    else
                    begin
                        logic w;
                        w = (pos_reg == 4'd0) ? (c == "S") : which_reg;
                        which_next = w;
                        if (c != (w ? sess_char(pos_reg) : depth_char(pos_reg)))
                            phase_next = PH_IGNORE;
                        else if (pos_reg + 4'd1 >= (w ? 4'd8 : 4'd6))
                        begin
                            phase_next = w ? PH_SESSION : PH_DEPTH;
                            pos_next = '0; kind_next = TK_EMPTY;
                            acc_next = '0; seen_next = 1'b0; bad_next = 1'b0;
                        end
                        else
                            pos_next = pos_reg + 4'd1;
                    end
                end
                PH_SESSION:
                begin
                    if (!bad_reg)
                    begin
                        if (!is_digit || ovf64) bad_next = 1'b1;
                        else begin acc_next = prod[63:0]; seen_next = 1'b1; end
                    end
                end
                PH_DEPTH:
                begin
                    if (c == " " || (eol && kind_reg != TK_EMPTY))
                    begin
                        // end of token (the eol case runs after a last byte below)
                        if (c == " ")
                        begin
                            case (kind_reg)
                                TK_VAL_SEQ:
                                begin
                                    hseq_next = !bad_reg && seen_reg;
                                    if (!bad_reg && seen_reg) wseq_next = acc_reg;
                                    kind_next = TK_EMPTY; pos_next = '0;
                                end
                                TK_VAL_BID, TK_VAL_ASK:
                                begin
                                    is_bid = (kind_reg == TK_VAL_BID);
                                    if (field_reg != 2'd2 || !seen_reg)
                                    begin
                                        err_next = is_bid ? ST_BAD_BID : ST_BAD_ASK;
                                        phase_next = PH_FAILED;
                                    end
                                    else
                                    begin
                                        wr_ord = 1'b1; wr_bid = is_bid;
                                        wr_slot_w = is_bid ? bcnt_reg : acnt_reg;
                                        if (is_bid) bcnt_next = bcnt_reg + 1'b1;
                                        else acnt_next = acnt_reg + 1'b1;
                                        kind_next = TK_EMPTY; pos_next = '0;
                                    end
                                end
                                default:
                                begin
                                    err_next = ST_BAD_DEPTH; phase_next = PH_FAILED;
                                end
                            endcase
                        end
                    end
                    if (c != " ")
                    begin
                        case (kind_reg)
                            TK_EMPTY, TK_KEY_SEQ, TK_KEY_BID, TK_KEY_ASK:
                            begin
                                tok_t k;
                                logic [7:0] exp_c;
                                logic [3:0] klen;
                                k = kind_reg;
                                if (kind_reg == TK_EMPTY)
                                begin
                                    if (c == "s") k = TK_KEY_SEQ;
                                    else if (c == "B") k = TK_KEY_BID;
                                    else if (c == "A") k = TK_KEY_ASK;
                                end
                                exp_c = (k == TK_KEY_SEQ) ? seq_char(pos_reg) :
                                        (pos_reg == 4'd0) ? ((k == TK_KEY_BID) ? "B" : "A")
                                                          : "=";
                                klen = (k == TK_KEY_SEQ) ? 4'd4 : 4'd2;
                                if (k == TK_EMPTY || c != exp_c)
                                begin
                                    err_next = ST_BAD_DEPTH; phase_next = PH_FAILED;
                                end
                                else if (pos_reg + 4'd1 >= klen)
                                begin
                                    acc_next = '0; seen_next = 1'b0; bad_next = 1'b0;
                                    field_next = '0; pos_next = pos_reg + 4'd1;
                                    if (k == TK_KEY_SEQ) kind_next = TK_VAL_SEQ;
                                    else if (k == TK_KEY_BID)
                                    begin
                                        if (32'(bcnt_reg) >= LEVELS)
                                        begin
                                            err_next = ST_BAD_DEPTH;
                                            phase_next = PH_FAILED; kind_next = k;
                                        end
                                        else kind_next = TK_VAL_BID;
                                    end
                                    else
                                    begin
                                        if (32'(acnt_reg) >= LEVELS)
                                        begin
                                            err_next = ST_BAD_DEPTH;
                                            phase_next = PH_FAILED; kind_next = k;
                                        end
                                        else kind_next = TK_VAL_ASK;
                                    end
                                end
                                else
                                begin
                                    kind_next = k; pos_next = pos_reg + 4'd1;
                                end
                            end
                            TK_VAL_SEQ:
                            begin
                                if (!bad_reg)
                                begin
                                    if (!is_digit || ovf64) bad_next = 1'b1;
                                    else begin acc_next = prod[63:0]; seen_next = 1'b1; end
                                end
                            end
                            default:
                            begin
                                is_bid = (kind_reg == TK_VAL_BID);
                                code = is_bid ? ST_BAD_BID : ST_BAD_ASK;
                                cnt = is_bid ? bcnt_reg : acnt_reg;
                                if (c == ",")
                                begin
                                    if (field_reg >= 2'd2 || !seen_reg)
                                    begin
                                        err_next = code; phase_next = PH_FAILED;
                                    end
                                    else
                                    begin
                                        wr_price = (field_reg == 2'd0);
                                        wr_qty = (field_reg == 2'd1);
                                        wr_bid = is_bid; wr_slot_w = cnt;
                                        field_next = field_reg + 2'd1;
                                        acc_next = '0; seen_next = 1'b0; bad_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    lvl_ovf = (field_reg == 2'd2) ? ovf32 : ovf64;
                                    if (!is_digit || lvl_ovf)
                                    begin
                                        err_next = code; phase_next = PH_FAILED;
                                    end
                                    else
                                    begin
                                        acc_next = prod[63:0]; seen_next = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase

            if (eol)
            begin
                handled_next = 1'b0;
                if (phase_next == PH_SESSION)
                begin
                    handled_next = 1'b1;
                    if (!bad_next && seen_next)
                    begin
                        sess_next = acc_next; status_next = ST_WAIT_DEPTH;
                    end
                    else status_next = ST_BAD_SESS;
                end
                else if (phase_next == PH_DEPTH || phase_next == PH_FAILED)
                begin
                    logic hs;
                    logic [CW-1:0] bc, ac;
                    handled_next = 1'b1;
                    hs = hseq_next; bc = bcnt_next; ac = acnt_next;
                    fin_ok = 1'b1;
                    if (phase_next == PH_DEPTH && kind_next != TK_EMPTY)
                    begin
                        case (kind_next)
                            TK_VAL_SEQ:
                            begin
                                hs = !bad_next && seen_next;
                                if (hs) wseq_next = acc_next;
                            end
                            TK_VAL_BID, TK_VAL_ASK:
                            begin
                                is_bid = (kind_next == TK_VAL_BID);
                                if (field_next != 2'd2 || !seen_next)
                                begin
                                    fin_ok = 1'b0;
                                    status_next = is_bid ? ST_BAD_BID : ST_BAD_ASK;
                                end
                                else
                                begin
                                    wr_ord = 1'b1; wr_bid = is_bid;
                                    wr_slot_w = is_bid ? bc : ac;
                                    if (is_bid) bc = bc + 1'b1;
                                    else ac = ac + 1'b1;
                                end
                            end
                            default:
                            begin
                                fin_ok = 1'b0; status_next = ST_BAD_DEPTH;
                            end
                        endcase
                    end
                    if (phase_next == PH_FAILED)
                        status_next = err_next;
                    else if (fin_ok)
                    begin
                        if (!hs || 32'(bc) != LEVELS || 32'(ac) != LEVELS)
                            status_next = ST_INCOMPLETE;
                        else
                        begin
                            status_next = ST_LIVE; commit_next = 1'b1;
                            seq_next = wseq_next;
                        end
                    end
                end
                phase_next = PH_PREFIX; kind_next = TK_EMPTY; pos_next = '0;
                field_next = '0; seen_next = 1'b0; bad_next = 1'b0; hseq_next = 1'b0;
                which_next = 1'b0; bcnt_next = '0; acnt_next = '0;
                err_next = ST_WAIT_DATA; acc_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX; kind_reg <= TK_EMPTY; pos_reg <= '0;
            field_reg <= '0; seen_reg <= 1'b0; bad_reg <= 1'b0; hseq_reg <= 1'b0;
            which_reg <= 1'b0; bcnt_reg <= '0; acnt_reg <= '0; err_reg <= '0;
            acc_reg <= '0; wseq_reg <= '0; sess_reg <= '0; seq_reg <= '0;
            status_reg <= ST_WAIT_DATA; handled_reg <= 1'b0; commit_reg <= 1'b0;
            slot_reg <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                bid_reg[i] <= '0;
                ask_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg <= phase_next; kind_reg <= kind_next; pos_reg <= pos_next;
            field_reg <= field_next; seen_reg <= seen_next; bad_reg <= bad_next;
            hseq_reg <= hseq_next; which_reg <= which_next; bcnt_reg <= bcnt_next;
            acnt_reg <= acnt_next; err_reg <= err_next; acc_reg <= acc_next;
            wseq_reg <= wseq_next; sess_reg <= sess_next; seq_reg <= seq_next;
            status_reg <= status_next; handled_reg <= handled_next;
            if (cmd.parse) commit_reg <= commit_next;
            if (cmd.slot_clr) slot_reg <= '0;
            else if (cmd.slot_inc)
                slot_reg <= (32'(slot_reg) == LEVELS - 1) ? '0 : slot_reg + 1'b1;
            // commit copies the working book when the status record is loaded, after the line's final write
            if (commit_reg && cmd.slot_clr && cmd.kind == KIND_STATUS)
            begin
                for (int i = 0; i < LEVELS; i++)
                begin
                    bid_reg[i] <= wbid[i];
                    ask_reg[i] <= wask[i];
                end
            end
        end
    end

    // order count at token end: the accumulator after this byte
    function automatic logic [31:0] acc_ord();
        return (cmd.parse && in_item.end_of_line && c != " " && is_digit && !ovf32
                && (kind_reg == TK_VAL_BID || kind_reg == TK_VAL_ASK))
               ? prod[31:0] : acc_reg[31:0];
    endfunction

    // working book, no reset
    always_ff @(posedge clk)
    begin
        if (wr_bid)
        begin
            if (wr_price) wbid[wr_slot].price  <= acc_reg;
            if (wr_qty)   wbid[wr_slot].qty    <= acc_reg;
            if (wr_ord)   wbid[wr_slot].orders <= acc_ord();
        end
        else
        begin
            if (wr_price) wask[wr_slot].price  <= acc_reg;
            if (wr_qty)   wask[wr_slot].qty    <= acc_reg;
            if (wr_ord)   wask[wr_slot].orders <= acc_ord();
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_reg.record_kind    <= cmd.kind;
            out_reg.line_handled   <= handled_reg;
            out_reg.status_code    <= status_reg;
            out_reg.session_number <= sess_reg;
            out_reg.depth_seq      <= seq_reg;
            out_reg.last_of_run    <= cmd.last;
            if (cmd.kind == KIND_STATUS)
            begin
                out_reg.level_slot    <= '0;
                out_reg.price_ticks   <= '0;
                out_reg.quantity_lots <= '0;
                out_reg.order_total   <= '0;
            end
            else
            begin
                out_reg.level_slot    <= 3'(slot_reg);
                out_reg.price_ticks   <= (cmd.kind == KIND_BID) ? bid_reg[slot_reg].price
                                                               : ask_reg[slot_reg].price;
                out_reg.quantity_lots <= (cmd.kind == KIND_BID) ? bid_reg[slot_reg].qty
                                                               : ask_reg[slot_reg].qty;
                out_reg.order_total   <= (cmd.kind == KIND_BID) ? bid_reg[slot_reg].orders
                                                               : ask_reg[slot_reg].orders;
            end
        end
    end

    assign out_item       = out_reg;
    assign stat.commit    = commit_reg;
    assign stat.slot_last = (32'(slot_reg) == LEVELS - 1);

endmodule

// ===== src/dslp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dslp_ctrl
// Handshake and emit sequencer for the line parser.
// ----------------------------------------------------------------------------
module dslp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_eol,
    output logic               out_valid,
    input  logic               out_ready,
    output dslp_pkg::dp_cmd_t  cmd,
    input  dslp_pkg::dp_stat_t stat
);
    import dslp_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       free;

    // output register free this cycle
    assign free = !ov_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.parse = 1'b1;
                    if (in_eol) state_next = CS_STATUS;
                end
            end
            CS_STATUS:
            begin
                if (free)
                begin
                    cmd.emit_load = 1'b1; cmd.kind = KIND_STATUS;
                    cmd.last = !stat.commit; cmd.slot_clr = 1'b1;
                    ov_next = 1'b1;
                    state_next = stat.commit ? CS_BIDS : CS_IDLE;
                end
            end
            CS_BIDS:
            begin
                if (free)
                begin
                    cmd.emit_load = 1'b1; cmd.kind = KIND_BID; cmd.slot_inc = 1'b1;
                    ov_next = 1'b1;
                    if (stat.slot_last) state_next = CS_ASKS;
                end
            end
            CS_ASKS:
            begin
                if (free)
                begin
                    cmd.emit_load = 1'b1; cmd.kind = KIND_ASK; cmd.slot_inc = 1'b1;
                    cmd.last = stat.slot_last; ov_next = 1'b1;
                    if (stat.slot_last) state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

// ===== src/depth_snapshot_line_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_snapshot_line_parser_top
// Line parser keeping a committed LEVELS-deep (default five) depth snapshot.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle mid-line.
// End of line: input held off while the status record is loaded and, when a book
// commits, while the LEVELS bid and LEVELS ask records follow (one record per
// cycle while out_ready stays high), each once the output register is free.
// Reset (rst_n, async low): empty book, session and seq 0, status waiting.
module depth_snapshot_line_parser_top #(
    parameter int LEVELS = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dslp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dslp_pkg::out_item_t out_data
);
    import dslp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dslp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_eol(in_data.end_of_line),
        .out_valid(out_valid), .out_ready(out_ready),
        .cmd(cmd), .stat(stat)
    );

    dslp_datapath #(.LEVELS(LEVELS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_data), .cmd(cmd), .stat(stat), .out_item(out_data)
    );

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.emit_load)
        else $error("output register overwritten");

    a_no_parse_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> !cmd.parse)
        else $error("parse during emit");

    a_eol_then_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.end_of_line) |=> !in_ready)
        else $error("input taken before status emitted");

endmodule

// ===== tb/depth_snapshot_line_parser_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_snapshot_line_parser_top_test
// Drives SESSION, DEPTH and other text lines into the parser one byte per
// transfer, predicts the status and level records per line, and checks every
// output transfer in order. Directed lines come from a table; random lines
// follow: well-formed snapshots with random numbers, SESSION lines and broken ones.
// ----------------------------------------------------------------------------
module depth_snapshot_line_parser_top_test;
    import dslp_pkg::*;

    localparam int NLEV = 5;
    localparam int WATCHDOG = 5000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    depth_snapshot_line_parser_top #(.LEVELS(NLEV)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------- predictor state ----------------
    logic [63:0] session_q, seq_q, work_seq, acc;
    logic [2:0]  status_q;
    level_t      bids_q [NLEV];
    level_t      asks_q [NLEV];
    level_t      work_b [NLEV];
    level_t      work_a [NLEV];
    phase_t      phase;
    tok_t        tok;
    int          pos, fld, bid_n, ask_n, which;
    logic        seen, bad, has_seq;
    logic [2:0]  err;

    out_item_t   expected_records[$];
    int          errors;
    int          idle_free;
    int          hold_off;

    function automatic void queue_record(input out_item_t r);
        expected_records.insert(expected_records.size(), r);
    endfunction

    function automatic logic num_byte(input logic [7:0] c, input logic [63:0] lim);
        logic [63:0] d;
        if (c < "0" || c > "9")
            return 1'b0;
        d = 64'(c - "0");
        if (acc > (lim - d) / 10)
            return 1'b0;
        acc = acc * 10 + d;
        seen = 1'b1;
        return 1'b1;
    endfunction

    function automatic void clear_line();
        phase = PH_PREFIX;
        acc = 0;
        tok = TK_EMPTY;
        pos = 0; fld = 0; bid_n = 0; ask_n = 0; which = 0;
        seen = 0; bad = 0; has_seq = 0; err = ST_WAIT_DATA;
    endfunction

    function automatic void set_fail(input logic [2:0] code);
        err = code;
        phase = PH_FAILED;
    endfunction

    function automatic void level_byte(input logic [7:0] c, input logic is_bid);
        int s;
        logic [2:0] code;
        s = is_bid ? bid_n : ask_n;
        code = is_bid ? ST_BAD_BID : ST_BAD_ASK;
        if (c == ",") begin
            if (fld >= 2 || !seen) begin
                set_fail(code);
                return;
            end
            if (is_bid) begin
                if (fld == 0) work_b[s].price = acc; else work_b[s].qty = acc;
            end
            else begin
                if (fld == 0) work_a[s].price = acc; else work_a[s].qty = acc;
            end
            fld++;
            acc = 0; seen = 0; bad = 0;
            return;
        end
        if (!num_byte(c, fld == 2 ? 64'hFFFF_FFFF : '1))
            set_fail(code);
    endfunction

    function automatic void open_value();
        acc = 0; seen = 0; bad = 0; fld = 0;
        if (tok == TK_KEY_SEQ)
            tok = TK_VAL_SEQ;
        else if (tok == TK_KEY_BID) begin
            if (bid_n >= NLEV) set_fail(ST_BAD_DEPTH); else tok = TK_VAL_BID;
        end
        else begin
            if (ask_n >= NLEV) set_fail(ST_BAD_DEPTH); else tok = TK_VAL_ASK;
        end
    endfunction

    function automatic logic [7:0] key_char(input tok_t k, input int p);
        string s;
        if (k == TK_KEY_SEQ) s = "seq=";
        else if (k == TK_KEY_BID) s = "B=";
        else s = "A=";
        return s[p];
    endfunction

    function automatic void token_byte(input logic [7:0] c);
        case (tok)
            TK_EMPTY: begin
                if (c == "s") tok = TK_KEY_SEQ;
                else if (c == "B") tok = TK_KEY_BID;
                else if (c == "A") tok = TK_KEY_ASK;
                else begin
                    set_fail(ST_BAD_DEPTH);
                    return;
                end
                pos = 1;
            end
            TK_KEY_SEQ, TK_KEY_BID, TK_KEY_ASK: begin
                if (c != key_char(tok, pos)) begin
                    set_fail(ST_BAD_DEPTH);
                    return;
                end
                pos++;
            end
            TK_VAL_SEQ: begin
                if (!bad && !num_byte(c, '1)) bad = 1'b1;
                return;
            end
            TK_VAL_BID: begin
                level_byte(c, 1'b1);
                return;
            end
            default: begin
                level_byte(c, 1'b0);
                return;
            end
        endcase
        if (pos >= ((tok == TK_KEY_SEQ) ? 4 : 2))
            open_value();
    endfunction

    function automatic void end_token();
        logic is_bid;
        case (tok)
            TK_VAL_SEQ: begin
                has_seq = !bad && seen;
                if (has_seq) work_seq = acc;
            end
            TK_VAL_BID, TK_VAL_ASK: begin
                is_bid = (tok == TK_VAL_BID);
                if (fld != 2 || !seen) begin
                    set_fail(is_bid ? ST_BAD_BID : ST_BAD_ASK);
                    return;
                end
                if (is_bid) begin
                    work_b[bid_n].orders = acc[31:0];
                    bid_n++;
                end
                else begin
                    work_a[ask_n].orders = acc[31:0];
                    ask_n++;
                end
            end
            default: begin
                set_fail(ST_BAD_DEPTH);
                return;
            end
        endcase
        tok = TK_EMPTY;
        pos = 0;
    endfunction

    function automatic void prefix_byte(input logic [7:0] c);
        string t;
        if (pos == 0) begin
            if (c == "S") which = 1;
            else if (c == "D") which = 2;
            else begin
                phase = PH_IGNORE;
                return;
            end
        end
        if (which == 1) t = "SESSION ";
        else t = "DEPTH ";
        if (c != t[pos]) begin
            phase = PH_IGNORE;
            return;
        end
        pos++;
        if (pos >= t.len()) begin
            phase = (which == 1) ? PH_SESSION : PH_DEPTH;
            pos = 0;
            tok = TK_EMPTY;
            acc = 0; seen = 0; bad = 0;
        end
    endfunction

    function automatic out_item_t make_rec(input logic [1:0] kind, input logic handled,
                                           input int slot, input level_t lv,
                                           input logic last);
        out_item_t r;
        r.record_kind = kind;
        r.line_handled = handled;
        r.status_code = status_q;
        r.session_number = session_q;
        r.depth_seq = seq_q;
        r.level_slot = 3'(slot);
        r.price_ticks = lv.price;
        r.quantity_lots = lv.qty;
        r.order_total = lv.orders;
        r.last_of_run = last;
        return r;
    endfunction

    // Advance the parser model by one byte; returns number of records queued.
    function automatic int parse_byte(input in_item_t it);
        logic handled, commit;
        int n;
        handled = 0; commit = 0; n = 0;
        case (phase)
            PH_PREFIX: prefix_byte(it.char_byte);
            PH_SESSION: if (!bad && !num_byte(it.char_byte, '1)) bad = 1'b1;
            PH_DEPTH: begin
                if (it.char_byte == " ") end_token();
                else token_byte(it.char_byte);
            end
            default: ;
        endcase
        if (!it.end_of_line)
            return 0;
        if (phase == PH_SESSION) begin
            handled = 1;
            if (!bad && seen) begin
                session_q = acc;
                status_q = ST_WAIT_DEPTH;
            end
            else
                status_q = ST_BAD_SESS;
        end
        else if (phase == PH_DEPTH || phase == PH_FAILED) begin
            handled = 1;
            if (phase == PH_DEPTH && tok != TK_EMPTY) end_token();
            if (phase == PH_FAILED)
                status_q = err;
            else if (!has_seq || bid_n != NLEV || ask_n != NLEV)
                status_q = ST_INCOMPLETE;
            else begin
                seq_q = work_seq;
                bids_q = work_b;
                asks_q = work_a;
                status_q = ST_LIVE;
                commit = 1;
            end
        end
        queue_record(make_rec(KIND_STATUS, handled, 0, '0, !commit));
        n++;
        if (commit) begin
            for (int i = 0; i < NLEV; i++)
                queue_record(make_rec(KIND_BID, handled, i, bids_q[i], 1'b0));
            for (int i = 0; i < NLEV; i++)
                queue_record(make_rec(KIND_ASK, handled, i, asks_q[i], i == NLEV - 1));
            n += 2 * NLEV;
        end
        clear_line();
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---------------- stimulus ----------------
    typedef struct {
        string      text;
        logic [2:0] status;   // ST_WAIT_DATA with check=0 means predictor only
        logic       check;
    } line_row_t;

    line_row_t dir_lines[$];
    string     pending_lines[$];

    function automatic string rand_num(input int digits);
        string s;
        s = "";
        for (int i = 0; i < digits; i++)
            s = {s, string'(8'("0" + $urandom_range(9)))};
        return s;
    endfunction

    function automatic string rand_level(input logic wide);
        string s;
        if (wide)
            s = $sformatf("%0d,%0d,%0d", {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        else
            s = $sformatf("%0d,%0d,%0d", $urandom_range(99999), $urandom_range(999),
                          $urandom_range(50));
        return s;
    endfunction

    function automatic string good_depth();
        string s;
        s = $sformatf("DEPTH seq=%0d", $urandom_range(1, 100000));
        for (int i = 0; i < NLEV; i++) s = {s, " B=", rand_level($urandom_range(3) == 0)};
        for (int i = 0; i < NLEV; i++) s = {s, " A=", rand_level($urandom_range(3) == 0)};
        return s;
    endfunction

    function automatic string random_line();
        string s;
        int k, p;
        byte c;
        k = $urandom_range(99);
        if (k < 45)
            return good_depth();
        if (k < 55)
            return {"SESSION ", rand_num($urandom_range(1, 22))};
        if (k < 80) begin
            // corrupt one byte of a good snapshot
            s = good_depth();
            p = $urandom_range(s.len() - 1);
            c = byte'($urandom_range(255));
            s[p] = (c == 0) ? 8'h80 : c;
            return s;
        end
        if (k < 88) begin
            s = good_depth();
            return s.substr(0, $urandom_range(6, s.len() - 1));
        end
        s = "";
        for (int i = 0; i < $urandom_range(1, 12); i++) begin
            c = byte'($urandom_range(1, 255));
            s = {s, string'(c)};
        end
        return s;
    endfunction

    // in_valid stays high across lines; it drops only on idle cycles
    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) begin
            while (idle_free == 0 && $urandom_range(99) < 13) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data.char_byte <= s[i];
            in_data.end_of_line <= (i == s.len() - 1);
            @(posedge clk iff in_ready);
            void'(parse_byte('{char_byte: s[i], end_of_line: (i == s.len() - 1)}));
        end
    endtask

    // ---------------- checker ----------------
    int quiet;
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_records.size() == 0)
                report_mismatch("unexpected record", out_data.record_kind, 0);
            else begin
                out_item_t w;
                w = expected_records.pop_front();
                if (out_data.record_kind !== w.record_kind)
                    report_mismatch("record_kind", out_data.record_kind, w.record_kind);
                if (out_data.line_handled !== w.line_handled)
                    report_mismatch("line_handled", out_data.line_handled, w.line_handled);
                if (out_data.status_code !== w.status_code)
                    report_mismatch("status_code", out_data.status_code, w.status_code);
                if (out_data.session_number !== w.session_number)
                    report_mismatch("session_number", out_data.session_number,
                                    w.session_number);
                if (out_data.depth_seq !== w.depth_seq)
                    report_mismatch("depth_seq", out_data.depth_seq, w.depth_seq);
                if (out_data.level_slot !== w.level_slot)
                    report_mismatch("level_slot", out_data.level_slot, w.level_slot);
                if (out_data.price_ticks !== w.price_ticks)
                    report_mismatch("price_ticks", out_data.price_ticks, w.price_ticks);
                if (out_data.quantity_lots !== w.quantity_lots)
                    report_mismatch("quantity_lots", out_data.quantity_lots, w.quantity_lots);
                if (out_data.order_total !== w.order_total)
                    report_mismatch("order_total", out_data.order_total, w.order_total);
                if (out_data.last_of_run !== w.last_of_run)
                    report_mismatch("last_of_run", out_data.last_of_run, w.last_of_run);
            end
        end
    end

    // receiver side: random stalls plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= (idle_free != 0) || ($urandom_range(99) >= 13);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("[depth_snapshot_line_parser_top] ERROR");
            $finish;
        end
    end

    initial begin
        string s, full;
        errors = 0; quiet = 0; idle_free = 0; hold_off = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        session_q = 0; seq_q = 0; status_q = ST_WAIT_DATA; work_seq = 0;
        for (int i = 0; i < NLEV; i++)
        begin
            bids_q[i] = '0; asks_q[i] = '0; work_b[i] = '0; work_a[i] = '0;
        end
        clear_line();

        full = "DEPTH seq=18446744073709551615";
        for (int i = 0; i < NLEV; i++) full = {full, " B=18446744073709551615,0,4294967295"};
        for (int i = 0; i < NLEV; i++) full = {full, " A=0,18446744073709551615,0"};
        dir_lines = '{
            '{"X",                          ST_WAIT_DATA,  1'b1},
            '{"DEPTH seq=1",                ST_INCOMPLETE, 1'b1},
            '{"SESSION 18446744073709551615", ST_WAIT_DEPTH, 1'b1},
            '{"SESSION 18446744073709551616", ST_BAD_SESS, 1'b1},
            '{"SESSION ",                   ST_BAD_SESS,   1'b1},
            '{"SESSION 0012",               ST_WAIT_DEPTH, 1'b1},
            '{"SESSIONX",                   ST_WAIT_DEPTH, 1'b1},
            '{"DEPTH  seq=1",               ST_BAD_DEPTH,  1'b1},
            '{"DEPTH q=1",                  ST_BAD_DEPTH,  1'b1},
            '{"DEPTH B=1,2",                ST_BAD_BID,    1'b1},
            '{"DEPTH A=1,2,3,4",            ST_BAD_ASK,    1'b1},
            '{"DEPTH B=1,2,4294967296",     ST_BAD_BID,    1'b1},
            '{"DEPTH A=,1,2",               ST_BAD_ASK,    1'b1},
            '{"DEPTH seq=1 ",               ST_INCOMPLETE, 1'b1},
            '{"",                           ST_WAIT_DATA,  1'b0},
            '{"",                           ST_WAIT_DATA,  1'b0},
            '{"",                           ST_WAIT_DATA,  1'b0},
            '{"",                           ST_WAIT_DATA,  1'b0},
            '{"\xff\x00",                   ST_WAIT_DATA,  1'b0}
        };
        // rows filled at run time: full extremes, bad seq then good, bad seq, surplus level
        dir_lines[14].text = full;
        s = good_depth();
        dir_lines[15].text = {s, " seq=x9 seq=77"};
        dir_lines[16].text = {s, " seq=12a"};
        dir_lines[17].text = {s, " B=1,1,1"};
        dir_lines[17].status = ST_BAD_DEPTH;
        dir_lines[17].check = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_lines[r]) begin
            send_line(dir_lines[r].text);
            if (dir_lines[r].check && expected_records.size() != 0) begin
                // the status record queued for this line must carry the typed-in code
                if (expected_records[expected_records.size() - 1 -
                        ((dir_lines[r].status == ST_LIVE) ? 2 * NLEV : 0)].status_code
                        !== dir_lines[r].status)
                    report_mismatch("table status", status_q, dir_lines[r].status);
            end
        end

        // long receiver hold-off while lines keep coming, so input backs up
        hold_off = 300;
        for (int i = 0; i < 4; i++) send_line(good_depth());

        for (int i = 0; i < 110; i++) begin
            idle_free = (i >= 40 && i < 60);
            send_line(random_line());
        end
        idle_free = 0;
        in_valid <= 1'b0;

        while (expected_records.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[depth_snapshot_line_parser_top] OK");
        else
            $display("[depth_snapshot_line_parser_top] ERROR");
        $finish;
    end

endmodule
